// ===== hdl/pgphd_pkg.sv =====
// shared types and constants for the packet header decoder
// used by every module of the block; depends on nothing
`default_nettype none

package pgphd_pkg;

  // width kept for the remaining buffer byte count
  localparam int BUFLEN_BITS = 32;
  // width used for the body-fits compare (at least the body length width)
  localparam int CMP_BITS    = (BUFLEN_BITS > 24) ? BUFLEN_BITS : 24;

  // stream bus widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // header decode constants
  localparam logic [7:0] NEW_ONE_MAX  = 8'd192;
  localparam logic [7:0] NEW_TWO_MAX  = 8'd224;
  localparam logic [7:0] NEW_FIVE_TAG = 8'd255;
  localparam logic [1:0] OLD_LEN_INDEF = 2'd3;
  localparam logic [1:0] OLD_LEN_FOUR  = 2'd2;

  // decoder phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_NEW_FIRST  = 6'b000010,
    PH_NEW_SECOND = 6'b000100,
    PH_NEW_ZERO   = 6'b001000,
    PH_OLD_TOP    = 6'b010000,
    PH_ACCUM      = 6'b100000
  } pgphd_phase_t;

  // one input item
  typedef struct packed {
    logic [31:0] buffer_len;
    logic        start_req;
    logic [7:0]  data_byte;
  } pgphd_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  header_len;
    logic [23:0] body_len;
    logic [5:0]  tag;
    logic        status;
  } pgphd_res_t;

endpackage

`default_nettype wire

// ===== hdl/pgphd_in_stage.sv =====
// input register of the packet header decoder
// holds one accepted byte transaction until the decoder takes it; uses pgphd_pkg
`default_nettype none

module pgphd_in_stage
  import pgphd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,   // data_byte [7:0], buffer_len [39:8]
  input  wire logic [0:0]            s_tuser,   // start_req [0]
  input  wire logic                  advance,
  output logic                       item_valid,
  output pgphd_item_t                item
);

  // free when empty or when the held item moves on this cycle
  assign s_tready = !item_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte  <= s_tdata[7:0];
      item.buffer_len <= s_tdata[39:8];
      item.start_req  <= s_tuser[0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pgphd_decode.sv =====
// header decode state and next-state logic
// one byte per step, flags a result when the outcome is known; uses pgphd_pkg
`default_nettype none

module pgphd_decode
  import pgphd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire pgphd_item_t item,
  output logic             emit,
  output pgphd_res_t       res
);

  pgphd_phase_t           phase, phase_next;
  logic [5:0]             saved_tag, saved_tag_next;
  logic [2:0]             len_left, len_left_next;
  logic [2:0]             hdr_count, hdr_count_next;
  logic [23:0]            len_accum, len_accum_next;
  logic [BUFLEN_BITS-1:0] buf_left, buf_left_next;

  logic [7:0]          b;
  logic                err;
  logic                finish;
  logic                fits;
  logic [CMP_BITS-1:0] cmp_left;
  logic [CMP_BITS-1:0] cmp_hlen;
  logic [CMP_BITS-1:0] cmp_body;
  logic [BUFLEN_BITS-1:0] old_need;

  assign b = item.data_byte;

  // next state for the byte in the input register
  always_comb begin
    phase_next     = phase;
    saved_tag_next = saved_tag;
    len_left_next  = len_left;
    hdr_count_next = hdr_count;
    len_accum_next = len_accum;
    buf_left_next  = buf_left;
    err            = 1'b0;
    finish         = 1'b0;
    old_need       = BUFLEN_BITS'(2);
    if (item.start_req) begin
      buf_left_next  = BUFLEN_BITS'(item.buffer_len);
      hdr_count_next = 3'd1;
      len_accum_next = '0;
      len_left_next  = '0;
      if (buf_left_next < BUFLEN_BITS'(2) || !b[7]) begin
        err = 1'b1;
      end else if (b[6]) begin
        saved_tag_next = b[5:0];
        phase_next     = PH_NEW_FIRST;
      end else begin
        saved_tag_next = {2'b00, b[5:2]};
        case (b[1:0])
          2'd0:    old_need = BUFLEN_BITS'(2);
          2'd1:    old_need = BUFLEN_BITS'(3);
          default: old_need = BUFLEN_BITS'(5);
        endcase
        if (b[1:0] == OLD_LEN_INDEF) begin
          err = 1'b1;
        end else if (buf_left_next < old_need) begin
          err = 1'b1;
        end else begin
          len_left_next = 3'(3'd1 << b[1:0]);
          phase_next    = (b[1:0] == OLD_LEN_FOUR) ? PH_OLD_TOP : PH_ACCUM;
        end
      end
    end else begin
      unique case (phase)
        PH_NEW_FIRST: begin
          hdr_count_next = 3'd2;
          if (b < NEW_ONE_MAX) begin
            len_accum_next = {16'd0, b};
            finish         = 1'b1;
          end else if (buf_left > BUFLEN_BITS'(3) && b < NEW_TWO_MAX) begin
            // b - 192 is the low five bits here
            len_accum_next = {11'd0, b[4:0], 8'd0};
            phase_next     = PH_NEW_SECOND;
          end else if (buf_left > BUFLEN_BITS'(6) && b == NEW_FIVE_TAG) begin
            phase_next = PH_NEW_ZERO;
          end else begin
            err = 1'b1;
          end
        end
        PH_NEW_SECOND: begin
          hdr_count_next = 3'd3;
          len_accum_next = len_accum + {16'd0, b} + 24'd192;
          finish         = 1'b1;
        end
        PH_NEW_ZERO, PH_OLD_TOP: begin
          hdr_count_next = hdr_count + 3'd1;
          if (b != 8'd0) begin
            err = 1'b1;
          end else begin
            len_accum_next = '0;
            len_left_next  = 3'd3;
            phase_next     = PH_ACCUM;
          end
        end
        PH_ACCUM: begin
          hdr_count_next = hdr_count + 3'd1;
          len_accum_next = {len_accum[15:0], b};
          if (len_left != 3'd0) begin
            len_left_next = len_left - 3'd1;
          end
          if (len_left_next == 3'd0) begin
            finish = 1'b1;
          end
        end
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // body must fit behind the header
  always_comb begin
    cmp_left = CMP_BITS'(buf_left_next);
    cmp_hlen = CMP_BITS'(hdr_count_next);
    cmp_body = CMP_BITS'(len_accum_next);
    fits     = (cmp_left >= cmp_hlen) && ((cmp_left - cmp_hlen) >= cmp_body);
  end

  // result fields
  always_comb begin
    emit           = err || finish;
    res.status     = err || !fits;
    res.tag        = '0;
    res.body_len   = '0;
    res.header_len = '0;
    if (!err && fits) begin
      res.tag        = saved_tag_next;
      res.body_len   = len_accum_next;
      res.header_len = hdr_count_next;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      saved_tag <= '0;
      len_left  <= '0;
      hdr_count <= '0;
      len_accum <= '0;
      buf_left  <= '0;
    end else if (step) begin
      phase     <= emit ? PH_IDLE : phase_next;
      saved_tag <= saved_tag_next;
      len_left  <= len_left_next;
      hdr_count <= hdr_count_next;
      len_accum <= len_accum_next;
      buf_left  <= buf_left_next;
    end
  end

  // checks
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("decoder phase not one-hot");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (emit && res.status) |-> (res.tag == 6'd0 && res.body_len == 24'd0 &&
                              res.header_len == 3'd0))
    else $error("corrupt result with nonzero fields");

  a_ok_hlen: assert property (@(posedge clk) disable iff (rst)
    (emit && !res.status) |-> (res.header_len >= 3'd2 && res.header_len <= 3'd6))
    else $error("header length out of range");

  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> (phase == PH_IDLE))
    else $error("decoder not idle after result");

endmodule

`default_nettype wire

// ===== hdl/pgphd_out_stage.sv =====
// result register of the packet header decoder
// holds one result transaction until the sink takes it; uses pgphd_pkg
`default_nettype none

module pgphd_out_stage
  import pgphd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire pgphd_res_t             res,
  output logic                        out_free,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // tag [5:0], body_len [29:6], header_len [32:30]
  output logic [0:0]                  m_tuser    // status [0]
);

  pgphd_res_t held;

  assign out_free = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= res;
    end
  end

  assign m_tdata = {7'd0, held.header_len, held.body_len, held.tag};
  assign m_tuser = held.status;

endmodule

`default_nettype wire

// ===== hdl/pgp_packet_header_decoder.sv =====
// OpenPGP packet header decoder, byte stream in, one result per packet header out.
// Takes one byte transaction per clock while the result register can take a result. A byte
// enters the input register, the decode logic updates the header state from it, and a result
// lands in the output register. Rate is one byte per cycle while the output is not stalled.
// A start byte (tuser set) also carries the buffer length and restarts decoding;
// after one result per header further bytes are dropped until the next start.
// Depends on pgphd_pkg, pgphd_in_stage, pgphd_decode and pgphd_out_stage.
`default_nettype none

module pgp_packet_header_decoder
  import pgphd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte [7:0], buffer_len [39:8]
  input  wire logic [0:0]             s_tuser,   // start_req [0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // tag [5:0], body_len [29:6], header_len [32:30]
  output logic [0:0]                  m_tuser    // status [0]
);

  pgphd_item_t item;
  pgphd_res_t  res;
  logic        item_valid;
  logic        out_free;
  logic        step;
  logic        emit;

  // decoder consumes a byte whenever the result register can take a result
  assign step = item_valid && out_free;

  pgphd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  pgphd_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .emit (emit),
    .res  (res)
  );

  pgphd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && emit),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
